### sv/hsv_to_rgb_converter_unit_macros.svh
// assertion helpers, clocked on clk and quiet while rst_n is low
`ifndef HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_MACROS_SVH

// property that must hold at every edge
`define HSV_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define HSV_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HSV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W  = 13;
    localparam int PCT_W  = 11;
    localparam int HM_W   = 11;
    localparam int DIST_W = 10;
    localparam int PROD_W = 22;
    localparam int NUM_W  = 32;
    localparam int SCL_W  = 22;
    localparam int RCP_W  = 41;
    localparam int BYTE_W = 8;
    localparam int LANES  = 3;

    localparam logic [HUE_W-1:0] HUE_60  = 13'd960;
    localparam logic [HUE_W-1:0] HUE_120 = 13'd1920;
    localparam logic [HUE_W-1:0] HUE_180 = 13'd2880;
    localparam logic [HUE_W-1:0] HUE_240 = 13'd3840;
    localparam logic [HUE_W-1:0] HUE_300 = 13'd4800;
    localparam logic [HUE_W-1:0] HUE_360 = 13'd5760;

    localparam logic [PCT_W-1:0] PCT_FULL = 11'd1600;

    // v * 1600 * 960, the full-scale numerator
    localparam logic [NUM_W-1:0] VN_SCALE  = 32'd1536000;
    localparam logic [NUM_W-1:0] MID_SCALE = 32'd960;

    // denominator 1600*1600*960 = 2^18 * 9375
    localparam logic [SCL_W-1:0] DIV_ODD  = 22'd9375;
    localparam logic [SCL_W-1:0] DIV_ODD2 = 22'd18750;
    localparam logic [RCP_W-1:0] RECIP    = 41'd458129;

    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } sector_t;

    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [SCL_W-1:0]  scl_t;
    typedef logic [BYTE_W-1:0] byte_t;

endpackage

`default_nettype wire

### sv/hsv_to_rgb_converter_unit.sv
// channel  side    beat fields (lowest bit up)
// s_axis   in      hue[13:0], saturation[25:14], brightness[37:26], zero pad [39:38]
// m_axis   out     red[7:0], green[15:8], blue[23:16]
//
// one beat per cycle sustained while m_axis_tready stays high, m_axis_tvalid rises once
// a beat has passed the seven register stages of the channel datapath
// rst_n clears the stage valid bits only, no beat is left in flight
// back-pressure moves stage by stage, so a stalled output still lets
// earlier stages fill their bubbles and nothing is lost or repeated
`timescale 1ns / 1ps
`default_nettype none

`include "hsv_to_rgb_converter_unit_macros.svh"

module hsv_to_rgb_converter_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // hue, saturation, brightness, pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata   // red, green, blue
);

    localparam int NS = 7;

    logic [NS:1]   valid_reg;
    logic [NS:1]   adv;
    logic [NS-1:1] blk_reg;

    // stage handshake
    always_comb
    begin
        adv[NS] = !valid_reg[NS] || m_axis_tready;
        for (int k = NS - 1; k >= 1; k--)
        begin
            adv[k] = !valid_reg[k] || adv[k + 1];
        end
    end

    assign s_axis_tready = adv[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                valid_reg[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (adv[k])
                begin
                    valid_reg[k] <= valid_reg[k - 1];
                end
            end
        end
    end

    // stage 1: range check, sector and distance from the nearest of 60, 180 or 300 degrees
    logic signed [13:0] in_hue;
    logic signed [11:0] in_sat;
    logic signed [11:0] in_bri;
    logic [hsv2rgb_pkg::HUE_W-1:0]  hue_mag;
    logic [hsv2rgb_pkg::HUE_W-1:0]  hm_wide;
    logic [hsv2rgb_pkg::HM_W-1:0]   hm;
    logic                           blk1_next;
    hsv2rgb_pkg::sector_t           sec1_next;
    logic [hsv2rgb_pkg::DIST_W-1:0] dist1_next;

    hsv2rgb_pkg::sector_t           sec1_reg;
    logic [hsv2rgb_pkg::PCT_W-1:0]  sat1_reg;
    logic [hsv2rgb_pkg::PCT_W-1:0]  bri1_reg;
    logic [hsv2rgb_pkg::DIST_W-1:0] dist1_reg;

    assign in_hue  = $signed(s_axis_tdata[13:0]);
    assign in_sat  = $signed(s_axis_tdata[25:14]);
    assign in_bri  = $signed(s_axis_tdata[37:26]);
    assign hue_mag = in_hue[12:0];

    always_comb
    begin
        blk1_next = in_hue[13] || (hue_mag > hsv2rgb_pkg::HUE_360)
                 || in_sat[11] || (in_sat[10:0] > hsv2rgb_pkg::PCT_FULL)
                 || in_bri[11] || (in_bri[10:0] > hsv2rgb_pkg::PCT_FULL);

        priority if (hue_mag < hsv2rgb_pkg::HUE_60)
            sec1_next = hsv2rgb_pkg::SEC_R_TO_Y;
        else if (hue_mag < hsv2rgb_pkg::HUE_120)
            sec1_next = hsv2rgb_pkg::SEC_Y_TO_G;
        else if (hue_mag < hsv2rgb_pkg::HUE_180)
            sec1_next = hsv2rgb_pkg::SEC_G_TO_C;
        else if (hue_mag < hsv2rgb_pkg::HUE_240)
            sec1_next = hsv2rgb_pkg::SEC_C_TO_B;
        else if (hue_mag < hsv2rgb_pkg::HUE_300)
            sec1_next = hsv2rgb_pkg::SEC_B_TO_M;
        else
            sec1_next = hsv2rgb_pkg::SEC_M_TO_R;

        // hue modulo 120 degrees
        priority if (hue_mag >= hsv2rgb_pkg::HUE_360)
            hm_wide = '0;
        else if (hue_mag >= hsv2rgb_pkg::HUE_240)
            hm_wide = hue_mag - hsv2rgb_pkg::HUE_240;
        else if (hue_mag >= hsv2rgb_pkg::HUE_120)
            hm_wide = hue_mag - hsv2rgb_pkg::HUE_120;
        else
            hm_wide = hue_mag;

        hm = hm_wide[hsv2rgb_pkg::HM_W-1:0];
        if (hm >= hsv2rgb_pkg::HM_W'(hsv2rgb_pkg::HUE_60))
            dist1_next = hsv2rgb_pkg::DIST_W'(hm - hsv2rgb_pkg::HM_W'(hsv2rgb_pkg::HUE_60));
        else
            dist1_next = hsv2rgb_pkg::DIST_W'(hsv2rgb_pkg::HM_W'(hsv2rgb_pkg::HUE_60) - hm);
    end

    // stage 2: chroma product and full-scale numerator
    logic [hsv2rgb_pkg::PROD_W-1:0] prod2_next;
    hsv2rgb_pkg::num_t              vn2_next;
    logic [hsv2rgb_pkg::PROD_W-1:0] prod2_reg;
    hsv2rgb_pkg::num_t              vn2_reg;
    logic [hsv2rgb_pkg::DIST_W-1:0] dist2_reg;
    hsv2rgb_pkg::sector_t           sec2_reg;

    assign prod2_next = {11'd0, sat1_reg} * {11'd0, bri1_reg};
    assign vn2_next   = {21'd0, bri1_reg} * hsv2rgb_pkg::VN_SCALE;

    // stage 3: chroma scaled by distance and by a full sector
    hsv2rgb_pkg::num_t    xm3_next;
    hsv2rgb_pkg::num_t    mm3_next;
    hsv2rgb_pkg::num_t    vn3_reg;
    hsv2rgb_pkg::num_t    xm3_reg;
    hsv2rgb_pkg::num_t    mm3_reg;
    hsv2rgb_pkg::sector_t sec3_reg;

    assign xm3_next = {10'd0, prod2_reg} * {22'd0, dist2_reg};
    assign mm3_next = {10'd0, prod2_reg} * hsv2rgb_pkg::MID_SCALE;

    // stage 4: channel numerators placed by sector
    hsv2rgb_pkg::num_t                           num_v;
    hsv2rgb_pkg::num_t                           num_x;
    hsv2rgb_pkg::num_t                           num_m;
    hsv2rgb_pkg::num_t [hsv2rgb_pkg::LANES-1:0] n4_next;
    hsv2rgb_pkg::num_t [hsv2rgb_pkg::LANES-1:0] n4_reg;

    always_comb
    begin
        num_v = vn3_reg;
        num_x = vn3_reg - xm3_reg;
        num_m = vn3_reg - mm3_reg;
        unique case (sec3_reg)
            hsv2rgb_pkg::SEC_R_TO_Y: n4_next = {num_m, num_x, num_v};
            hsv2rgb_pkg::SEC_Y_TO_G: n4_next = {num_m, num_v, num_x};
            hsv2rgb_pkg::SEC_G_TO_C: n4_next = {num_x, num_v, num_m};
            hsv2rgb_pkg::SEC_C_TO_B: n4_next = {num_v, num_x, num_m};
            hsv2rgb_pkg::SEC_B_TO_M: n4_next = {num_v, num_m, num_x};
            hsv2rgb_pkg::SEC_M_TO_R: n4_next = {num_x, num_m, num_v};
            default:                 n4_next = '0;
        endcase
    end

    // stage 5: times 255, power-of-two part of the denominator dropped
    logic [39:0]                                 p5 [hsv2rgb_pkg::LANES];
    hsv2rgb_pkg::scl_t [hsv2rgb_pkg::LANES-1:0] t5_next;
    hsv2rgb_pkg::scl_t [hsv2rgb_pkg::LANES-1:0] t5_reg;

    always_comb
    begin
        for (int i = 0; i < hsv2rgb_pkg::LANES; i++)
        begin
            p5[i]      = {n4_reg[i], 8'd0} - {8'd0, n4_reg[i]};
            t5_next[i] = p5[i][39:18];
        end
    end

    // stage 6: reciprocal estimate of the quotient by 9375
    logic [hsv2rgb_pkg::RCP_W-1:0]                q6 [hsv2rgb_pkg::LANES];
    hsv2rgb_pkg::byte_t [hsv2rgb_pkg::LANES-1:0] q6_next;
    hsv2rgb_pkg::byte_t [hsv2rgb_pkg::LANES-1:0] q6_reg;
    hsv2rgb_pkg::scl_t  [hsv2rgb_pkg::LANES-1:0] t6_reg;

    always_comb
    begin
        for (int i = 0; i < hsv2rgb_pkg::LANES; i++)
        begin
            q6[i]      = {19'd0, t5_reg[i]} * hsv2rgb_pkg::RECIP;
            q6_next[i] = q6[i][39:32];
        end
    end

    // stage 7: correct the estimate by one, black forced to zero
    hsv2rgb_pkg::scl_t  [hsv2rgb_pkg::LANES-1:0] corr_rem;
    hsv2rgb_pkg::byte_t [hsv2rgb_pkg::LANES-1:0] ch7_next;
    hsv2rgb_pkg::byte_t [hsv2rgb_pkg::LANES-1:0] ch7_reg;

    always_comb
    begin
        for (int i = 0; i < hsv2rgb_pkg::LANES; i++)
        begin
            corr_rem[i] = t6_reg[i] - ({14'd0, q6_reg[i]} * hsv2rgb_pkg::DIV_ODD);
            if (blk_reg[6])
                ch7_next[i] = '0;
            else if (corr_rem[i] >= hsv2rgb_pkg::DIV_ODD)
                ch7_next[i] = q6_reg[i] + 8'd1;
            else
                ch7_next[i] = q6_reg[i];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            blk_reg[1] <= blk1_next;
            sec1_reg   <= sec1_next;
            sat1_reg   <= in_sat[10:0];
            bri1_reg   <= in_bri[10:0];
            dist1_reg  <= dist1_next;
        end
        if (adv[2])
        begin
            blk_reg[2] <= blk_reg[1];
            prod2_reg  <= prod2_next;
            vn2_reg    <= vn2_next;
            dist2_reg  <= dist1_reg;
            sec2_reg   <= sec1_reg;
        end
        if (adv[3])
        begin
            blk_reg[3] <= blk_reg[2];
            vn3_reg    <= vn2_reg;
            xm3_reg    <= xm3_next;
            mm3_reg    <= mm3_next;
            sec3_reg   <= sec2_reg;
        end
        if (adv[4])
        begin
            blk_reg[4] <= blk_reg[3];
            n4_reg     <= n4_next;
        end
        if (adv[5])
        begin
            blk_reg[5] <= blk_reg[4];
            t5_reg     <= t5_next;
        end
        if (adv[6])
        begin
            blk_reg[6] <= blk_reg[5];
            q6_reg     <= q6_next;
            t6_reg     <= t5_reg;
        end
        if (adv[7])
        begin
            ch7_reg    <= ch7_next;
        end
    end

    assign m_axis_tvalid = valid_reg[NS];
    assign m_axis_tdata  = {ch7_reg[2], ch7_reg[1], ch7_reg[0]};

    // checks
    `HSV_ASSERT_NEXT(a_neg_hue_black, s_axis_tvalid && s_axis_tready && in_hue[13], blk_reg[1], "negative hue not marked black")
    `HSV_ASSERT_NEXT(a_stall_holds, valid_reg[4] && !adv[5], valid_reg[4] && $stable(n4_reg), "stalled stage lost its beat")
    `HSV_ASSERT_IMPL(a_rem_bound, valid_reg[6] && !blk_reg[6], corr_rem[0] < hsv2rgb_pkg::DIV_ODD2 && corr_rem[1] < hsv2rgb_pkg::DIV_ODD2 && corr_rem[2] < hsv2rgb_pkg::DIV_ODD2, "quotient estimate off by more than one")
    `HSV_ASSERT_ALWAYS(a_bubble_ready, valid_reg[1] || s_axis_tready, "input stalled with first stage empty")
    `HSV_ASSERT_NEXT(a_out_black, valid_reg[6] && blk_reg[6] && adv[7], m_axis_tdata == 24'd0, "black beat carries colour")

endmodule

`default_nettype wire
